@@ sv/lkv_pkg.sv @@
// lkv_pkg: shared types and fixed field widths of the lru key-value cache
// depends on nothing; imported by the front, back and top modules
package lkv_pkg;

   localparam int OP_W   = 2;
   localparam int KEY_W  = 64;
   localparam int DATA_W = 64;
   localparam int LEN_W  = 4;
   localparam int CFG_W  = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_GET    = 2'd0,
      OP_SET    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

endpackage

@@ sv/lkv_if.sv @@
// lkv_if: valid/ready channel interfaces for request and response words
// depends on nothing; widths match the fixed fields in lkv_pkg
interface lkv_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] key;
   logic [63:0] write_data;
   logic [3:0]  data_len;

   modport source (output valid, op, key, write_data, data_len, input ready);
   modport sink   (input valid, op, key, write_data, data_len, output ready);
endinterface

interface lkv_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic        evicted;
   logic [63:0] read_data;
   logic [3:0]  read_len;

   modport source (output valid, found, evicted, read_data, read_len, input ready);
   modport sink   (input valid, found, evicted, read_data, read_len, output ready);
endinterface

@@ sv/lru_key_value_cache.sv @@
// lru_key_value_cache: top level, max_entries register, front and back wiring
// depends on lkv_pkg, lkv_if, lkv_front and lkv_back
//
//   channel  dir  handshake            word
//   req      in   req.valid/req.ready  op, key, write_data, data_len
//   rsp      out  rsp.valid/rsp.ready  found, evicted, read_data, read_len
//   csr      in   csr_wr_en            csr_wr_data (max_entries)
//
// one request at a time in the back: a serial key scan through the entry
// memory, one entry a cycle, stops at the hit, then an exec step; a set
// adds a free-slot search. a two-word queue lets the front take words while
// the back is busy. reset is synchronous; it clears all entries and sets
// max_entries to 16.
module lru_key_value_cache #(
   parameter int ENTRIES       = 16,
   parameter int KEY_BITS      = 64,
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   lkv_req_if.sink    req,
   lkv_rsp_if.source  rsp,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);
   import lkv_pkg::*;

   logic [CFG_W-1:0] max_entries_ff;

   logic                       q_valid;
   logic                       q_ready;
   op_type                     q_op;
   logic [KEY_BITS-1:0]        q_key;
   logic [8*PAYLOAD_BYTES-1:0] q_data;
   logic [LEN_W-1:0]           q_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         max_entries_ff <= csr_wr_data;
      end
   end

   lkv_front #(
      .KEY_BITS      (KEY_BITS),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_op    (q_op),
      .q_key   (q_key),
      .q_data  (q_data),
      .q_len   (q_len)
   );

   lkv_back #(
      .ENTRIES       (ENTRIES),
      .KEY_BITS      (KEY_BITS),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .max_entries (max_entries_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_op        (q_op),
      .q_key       (q_key),
      .q_data      (q_data),
      .q_len       (q_len),
      .rsp         (rsp)
   );

`ifndef ASSERT_OFF
   a_queue_hold: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid && $stable(q_key) && $stable(q_len))
      else $error("queued word changed while back was busy");

   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> max_entries_ff == $past(csr_wr_data))
      else $error("max_entries write lost");

   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.found |-> rsp.read_len == 4'd0 && rsp.read_data == 64'd0)
      else $error("miss returned data");

   a_evict_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.evicted |-> rsp.read_len == 4'd0)
      else $error("evicting set returned data");
`endif

endmodule

@@ sv/lkv_front.sv @@
// lkv_front: accepts request words, decodes and normalizes them, queues them
// depends on lkv_pkg and lkv_req_if
module lkv_front #(
   parameter int KEY_BITS      = 64,
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   lkv_req_if.sink                 req,
   output logic                    q_valid,
   input  logic                    q_ready,
   output lkv_pkg::op_type         q_op,
   output logic [KEY_BITS-1:0]     q_key,
   output logic [8*PAYLOAD_BYTES-1:0] q_data,
   output logic [3:0]              q_len
);
   import lkv_pkg::*;

   localparam int PW = 8 * PAYLOAD_BYTES;

   op_type              slot_op_ff   [2];
   logic [KEY_BITS-1:0] slot_key_ff  [2];
   logic [PW-1:0]       slot_data_ff [2];
   logic [LEN_W-1:0]    slot_len_ff  [2];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   logic [LEN_W-1:0] len_c;
   logic [PW-1:0]    data_c;
   logic             push, pop;

   always_comb begin
      len_c = (req.data_len > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES) : req.data_len;
      // bytes past the stored length are dropped here
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         data_c[8*b +: 8] = (LEN_W'(b) < len_c) ? req.write_data[8*b +: 8] : 8'h00;
      end
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign pop       = q_valid && q_ready;

   assign q_op   = slot_op_ff[rd_ptr_ff];
   assign q_key  = slot_key_ff[rd_ptr_ff];
   assign q_data = slot_data_ff[rd_ptr_ff];
   assign q_len  = slot_len_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_op_ff[wr_ptr_ff]   <= op_type'(req.op);
         slot_key_ff[wr_ptr_ff]  <= req.key[KEY_BITS-1:0];
         slot_data_ff[wr_ptr_ff] <= data_c;
         slot_len_ff[wr_ptr_ff]  <= len_c;
      end
   end

endmodule

@@ sv/lkv_back.sv @@
// lkv_back: executes queued requests against the entry store, drives responses
// depends on lkv_pkg and lkv_rsp_if; key/payload memory lives here
module lkv_back #(
   parameter int ENTRIES       = 16,
   parameter int KEY_BITS      = 64,
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [4:0]                 max_entries,
   input  logic                       q_valid,
   output logic                       q_ready,
   input  lkv_pkg::op_type            q_op,
   input  logic [KEY_BITS-1:0]        q_key,
   input  logic [8*PAYLOAD_BYTES-1:0] q_data,
   input  logic [3:0]                 q_len,
   lkv_rsp_if.source                  rsp
);
   import lkv_pkg::*;

   localparam int PW = 8 * PAYLOAD_BYTES;
   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int MW = KEY_BITS + PW + LEN_W;
   localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_EXEC = 5'b00100,
      ST_FREE = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type st_ff, st_in;

   op_type              op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [PW-1:0]       data_ff, data_in;
   logic [LEN_W-1:0]    len_ff, len_in;

   logic [IW-1:0] addr_ff, addr_in;
   logic          issue_ff, issue_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;

   logic [MW-1:0] mem [ENTRIES];
   logic [MW-1:0] rword_ff;
   logic          mem_we;

   logic             hit_ff, hit_in;
   logic [IW-1:0]    hit_idx_ff, hit_idx_in;
   logic [PW-1:0]    hit_data_ff, hit_data_in;
   logic [LEN_W-1:0] hit_len_ff, hit_len_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]      age_ff [ENTRIES];
   logic [IW-1:0]      age_in [ENTRIES];
   logic [CW-1:0]      cnt_ff, cnt_in;

   logic             res_found_ff, res_found_in;
   logic             res_evict_ff, res_evict_in;
   logic [PW-1:0]    res_data_ff, res_data_in;
   logic [LEN_W-1:0] res_len_ff, res_len_in;

   logic             out_valid_ff, out_valid_in;
   logic             out_found_ff, out_found_in;
   logic             out_evict_ff, out_evict_in;
   logic [63:0]      out_data_ff, out_data_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;

   // per-entry views used by exec
   logic [CW-1:0]      lim;
   logic [IW-1:0]      hit_age;
   logic [IW-1:0]      t_age [ENTRIES];
   logic [IW-1:0]      d_age [ENTRIES];
   logic [ENTRIES-1:0] d_valid, e_valid;
   logic [CW-1:0]      d_cnt;
   logic               need_evict;
   logic               key_match;
   logic [LEN_W-1:0]   n_len;

   always_comb begin
      if (max_entries == 5'd0) begin
         lim = CW'(1);
      end else if (32'(max_entries) > ENTRIES) begin
         lim = CW'(ENTRIES);
      end else begin
         lim = CW'(max_entries);
      end
   end

   assign key_match = valid_ff[rd_idx_ff] && (rword_ff[MW-1 -: KEY_BITS] == key_ff);
   assign hit_age   = age_ff[hit_idx_ff];
   assign n_len     = (hit_len_ff < len_ff) ? hit_len_ff : len_ff;

   always_comb begin
      d_cnt      = cnt_ff - CW'(hit_ff);
      need_evict = (d_cnt >= lim);
      for (int i = 0; i < ENTRIES; i++) begin
         t_age[i] = (valid_ff[i] && age_ff[i] < hit_age) ? age_ff[i] + 1'b1 : age_ff[i];
         d_age[i] = (valid_ff[i] && age_ff[i] > hit_age && hit_ff) ?
                    age_ff[i] - 1'b1 : age_ff[i];
         d_valid[i] = valid_ff[i] && !(hit_ff && IW'(i) == hit_idx_ff);
         // ranks are dense, so the least recent ones are those at or past lim-1
         e_valid[i] = d_valid[i] && !(need_evict && CW'(d_age[i]) >= lim - 1'b1);
      end
      t_age[hit_idx_ff] = '0;
   end

   always_comb begin
      st_in        = st_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      len_in       = len_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_data_in  = hit_data_ff;
      hit_len_in   = hit_len_ff;
      valid_in     = valid_ff;
      age_in       = age_ff;
      cnt_in       = cnt_ff;
      res_found_in = res_found_ff;
      res_evict_in = res_evict_ff;
      res_data_in  = res_data_ff;
      res_len_in   = res_len_ff;
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      out_evict_in = out_evict_ff;
      out_data_in  = out_data_ff;
      out_len_in   = out_len_ff;
      mem_we       = 1'b0;
      q_ready      = 1'b0;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (st_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               op_in    = q_op;
               key_in   = q_key;
               data_in  = q_data;
               len_in   = q_len;
               addr_in  = '0;
               issue_in = 1'b1;
               pend_in  = 1'b0;
               hit_in   = 1'b0;
               st_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in   = issue_ff;
            rd_idx_in = addr_ff;
            if (issue_ff) begin
               addr_in  = addr_ff + 1'b1;
               issue_in = (addr_ff != LAST);
            end
            if (pend_ff) begin
               if (key_match) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = rd_idx_ff;
                  hit_data_in = rword_ff[LEN_W +: PW];
                  hit_len_in  = rword_ff[LEN_W-1:0];
                  issue_in    = 1'b0;
                  pend_in     = 1'b0;
                  st_in       = ST_EXEC;
               end else if (rd_idx_ff == LAST) begin
                  st_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            res_found_in = hit_ff;
            res_evict_in = 1'b0;
            res_data_in  = '0;
            res_len_in   = '0;
            st_in        = ST_DONE;
            case (op_ff)
               OP_GET: begin
                  if (hit_ff) begin
                     res_len_in = n_len;
                     for (int b = 0; b < PAYLOAD_BYTES; b++) begin
                        res_data_in[8*b +: 8] = (LEN_W'(b) < n_len) ?
                                                hit_data_ff[8*b +: 8] : 8'h00;
                     end
                     age_in = t_age;
                  end
               end
               OP_SET: begin
                  age_in       = d_age;
                  valid_in     = e_valid;
                  cnt_in       = need_evict ? lim - 1'b1 : d_cnt;
                  res_evict_in = need_evict;
                  addr_in      = '0;
                  st_in        = ST_FREE;
               end
               OP_REMOVE: begin
                  age_in   = d_age;
                  valid_in = d_valid;
                  cnt_in   = d_cnt;
               end
               default: begin
               end
            endcase
         end
         ST_FREE: begin
            if (!valid_ff[addr_ff]) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i]) begin
                     age_in[i] = age_ff[i] + 1'b1;
                  end
               end
               age_in[addr_ff]   = '0;
               valid_in[addr_ff] = 1'b1;
               cnt_in            = cnt_ff + 1'b1;
               mem_we            = 1'b1;
               st_in             = ST_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_found_in = res_found_ff;
               out_evict_in = res_evict_ff;
               out_data_in  = 64'(res_data_ff);
               out_len_in   = res_len_ff;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         st_ff        <= st_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         age_ff       <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      data_ff      <= data_in;
      len_ff       <= len_in;
      addr_ff      <= addr_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_data_ff  <= hit_data_in;
      hit_len_ff   <= hit_len_in;
      res_found_ff <= res_found_in;
      res_evict_ff <= res_evict_in;
      res_data_ff  <= res_data_in;
      res_len_ff   <= res_len_in;
      out_found_ff <= out_found_in;
      out_evict_ff <= out_evict_in;
      out_data_ff  <= out_data_in;
      out_len_ff   <= out_len_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= {key_ff, data_ff, len_ff};
      end
      rword_ff <= mem[addr_ff];
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.found     = out_found_ff;
   assign rsp.evicted   = out_evict_ff;
   assign rsp.read_data = out_data_ff;
   assign rsp.read_len  = out_len_ff;

endmodule
